@@ rtl/abpb_pkg.sv @@
// Shared types and constants for the audio block peak builder.
package abpb_pkg;

  localparam int SAMPLE_W             = 16;
  localparam int PEAK_W               = 15;
  localparam int BLOCK_W              = 24;
  localparam int CFG_INDEX_W          = 1;
  localparam int CFG_DATA_W           = 24;
  localparam int DEFAULT_BLOCK_FRAMES = 128;

  localparam logic signed [SAMPLE_W-1:0] Q15_NEG_FULL = -16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] Q15_NEG_CODE = -16'sd32768;

  localparam logic [CFG_INDEX_W-1:0] CFG_STEREO_MODE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_BLOCK = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       last_frame;
  } in_item_t;

  typedef struct packed {
    logic [BLOCK_W-1:0]         block_number;
    logic signed [SAMPLE_W-1:0] left_min;
    logic [PEAK_W-1:0]          left_max;
    logic signed [SAMPLE_W-1:0] right_min;
    logic [PEAK_W-1:0]          right_max;
    logic                       final_block;
  } out_item_t;

  typedef struct packed {
    logic upd;
    logic flush;
  } lane_ctl_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] run_min;
    logic [PEAK_W-1:0]          run_max;
  } lane_peak_t;

endpackage

@@ rtl/abpb_lane.sv @@
// One channel lane: saturate the sample and track block minimum and maximum.
module abpb_lane import abpb_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  lane_ctl_t                  ctl,
  input  logic signed [SAMPLE_W-1:0] sample,
  output lane_peak_t                 peak
);

  logic signed [SAMPLE_W-1:0] run_min;
  logic [PEAK_W-1:0]          run_max;
  logic signed [SAMPLE_W-1:0] sat;
  logic signed [SAMPLE_W-1:0] run_min_next;
  logic [PEAK_W-1:0]          run_max_next;

  always_comb begin
    sat = (sample == Q15_NEG_CODE) ? Q15_NEG_FULL : sample;
    run_min_next = run_min;
    run_max_next = run_max;
    if (ctl.upd) begin
      if (sat < run_min) begin
        run_min_next = sat;
      end
      if (sat > $signed({1'b0, run_max})) begin
        run_max_next = sat[PEAK_W-1:0];
      end
    end
  end

  assign peak.run_min = run_min_next;
  assign peak.run_max = run_max_next;

  always_ff @(posedge clk) begin
    if (rst || ctl.flush) begin
      run_min <= '0;
      run_max <= '0;
    end else begin
      run_min <= run_min_next;
      run_max <= run_max_next;
    end
  end

endmodule

@@ rtl/abpb_merge.sv @@
// Merge lane peaks into one result and hold it in a two-entry output buffer.
module abpb_merge import abpb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [BLOCK_W-1:0] block_number,
  input  lane_peak_t         left_peak,
  input  lane_peak_t         right_peak,
  input  logic               stereo,
  input  logic               last,
  output logic               full,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data
);

  out_item_t item;
  out_item_t skid_data;
  logic      skid_valid;
  logic      pop;

  always_comb begin
    item.block_number = block_number;
    item.left_min     = left_peak.run_min;
    item.left_max     = left_peak.run_max;
    item.right_min    = stereo ? right_peak.run_min : '0;
    item.right_max    = stereo ? right_peak.run_max : '0;
    item.final_block  = last;
  end

  assign pop  = out_valid && out_ready;
  assign full = out_valid && skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      out_valid  <= skid_valid || push;
      skid_valid <= skid_valid && push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : item;
      if (skid_valid && push) begin
        skid_data <= item;
      end
    end else if (push) begin
      skid_data <= item;
    end
  end

endmodule

@@ rtl/audio_block_peak_builder_unit.sv @@
// Top level: min/max peak decimation of an audio frame stream over fixed blocks.
// Throughput: one frame accepted per cycle unless the output buffer is full; the lanes
// update in parallel, the right one in stereo mode only. The frame that closes a block
// registers its result in a two-entry output buffer that keeps input flowing as it waits.
// Reset: mono mode, first block 0, counters and running peaks cleared, buffer empty.
module audio_block_peak_builder_unit import abpb_pkg::*; #(
  parameter int BLOCK_FRAMES = DEFAULT_BLOCK_FRAMES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  in_item_t               in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int CNT_W = $clog2(BLOCK_FRAMES);
  localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(BLOCK_FRAMES - 1);

  logic               stereo_mode;
  logic [BLOCK_W-1:0] first_block;
  logic [BLOCK_W-1:0] current_block;
  logic [CNT_W-1:0]   frame_in_block;
  logic               accept;
  logic               emit;
  logic               cfg_write;
  logic               clear_block;
  logic               full;
  lane_ctl_t          left_ctl;
  lane_ctl_t          right_ctl;
  lane_peak_t         left_peak;
  lane_peak_t         right_peak;

  assign cfg_ready   = 1'b1;
  assign cfg_write   = cfg_valid && cfg_ready;
  assign in_ready    = !full;
  assign accept      = in_valid && in_ready;
  assign emit        = accept && (in_data.last_frame || frame_in_block == LAST_COUNT);
  assign clear_block = emit || (cfg_write && cfg_index == CFG_FIRST_BLOCK);

  always_comb begin
    left_ctl.upd    = accept;
    left_ctl.flush  = clear_block;
    right_ctl.upd   = accept && stereo_mode;
    right_ctl.flush = clear_block;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stereo_mode    <= 1'b0;
      first_block    <= '0;
      current_block  <= '0;
      frame_in_block <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_STEREO_MODE: begin
          stereo_mode <= cfg_data[0];
        end
        CFG_FIRST_BLOCK: begin
          first_block    <= cfg_data[BLOCK_W-1:0];
          current_block  <= cfg_data[BLOCK_W-1:0];
          frame_in_block <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      if (emit) begin
        frame_in_block <= '0;
        current_block  <= in_data.last_frame ? first_block : current_block + 1'b1;
      end else begin
        frame_in_block <= frame_in_block + 1'b1;
      end
    end
  end

  abpb_lane u_left_lane (
    .clk    (clk),
    .rst    (rst),
    .ctl    (left_ctl),
    .sample (in_data.left_sample),
    .peak   (left_peak)
  );

  abpb_lane u_right_lane (
    .clk    (clk),
    .rst    (rst),
    .ctl    (right_ctl),
    .sample (in_data.right_sample),
    .peak   (right_peak)
  );

  abpb_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .push         (emit),
    .block_number (current_block),
    .left_peak    (left_peak),
    .right_peak   (right_peak),
    .stereo       (stereo_mode),
    .last         (in_data.last_frame),
    .full         (full),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

@@ test/audio_block_peak_builder_unit_test.sv @@
// Self-checking testbench for the audio block peak builder, checked per transfer.
`timescale 1ns / 100ps

module audio_block_peak_builder_unit_test;
  import abpb_pkg::*;

  localparam int SETTLE_CYCLES = 4;
  localparam int LONG_HOLD     = 800;
  localparam int PLAN_ROWS     = 24;

  typedef enum logic {ROW_FRAME, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t               kind;
    in_item_t                frame;
    logic [CFG_INDEX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0]   reg_value;
    bit                      typed;
    out_item_t               result;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_item_t               in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int unsigned send_gap_pct = 0;
  int unsigned recv_gap_pct = 0;
  bit          hold_req = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned mismatches = 0;
  int unsigned peaks_seen = 0;

  out_item_t pending_peaks[$];

  logic                       stereo_on;
  logic [BLOCK_W-1:0]         base_block;
  logic [BLOCK_W-1:0]         blk_now;
  int unsigned                frames_in;
  logic signed [SAMPLE_W-1:0] pk_lmin, pk_lmax, pk_rmin, pk_rmax;

  audio_block_peak_builder_unit #(.BLOCK_FRAMES(DEFAULT_BLOCK_FRAMES)) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void clear_peaks();
    frames_in = 0;
    pk_lmin   = '0;
    pk_lmax   = '0;
    pk_rmin   = '0;
    pk_rmax   = '0;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clamp_q15(input logic signed [SAMPLE_W-1:0] s);
    return (s == Q15_NEG_CODE) ? Q15_NEG_FULL : s;
  endfunction

  function automatic bit advance_peaks(input in_item_t f, output out_item_t res);
    logic signed [SAMPLE_W-1:0] l;
    logic signed [SAMPLE_W-1:0] r;
    l   = clamp_q15(f.left_sample);
    r   = clamp_q15(f.right_sample);
    res = '0;
    if (l < pk_lmin) pk_lmin = l;
    if (l > pk_lmax) pk_lmax = l;
    if (stereo_on) begin
      if (r < pk_rmin) pk_rmin = r;
      if (r > pk_rmax) pk_rmax = r;
    end
    frames_in++;
    if (frames_in < DEFAULT_BLOCK_FRAMES && !f.last_frame) return 1'b0;
    res.block_number = blk_now;
    res.left_min     = pk_lmin;
    res.left_max     = pk_lmax[PEAK_W-1:0];
    res.right_min    = stereo_on ? pk_rmin : '0;
    res.right_max    = stereo_on ? pk_rmax[PEAK_W-1:0] : '0;
    res.final_block  = f.last_frame;
    clear_peaks();
    blk_now = f.last_frame ? base_block : blk_now + 1'b1;
    return 1'b1;
  endfunction

  function automatic stim_row_t frame_row(input logic signed [SAMPLE_W-1:0] l,
                                          input logic signed [SAMPLE_W-1:0] r,
                                          input logic last);
    stim_row_t row;
    row = '{kind: ROW_FRAME, frame: '0, reg_index: '0, reg_value: '0, typed: 1'b0, result: '0};
    row.frame.left_sample  = l;
    row.frame.right_sample = r;
    row.frame.last_frame   = last;
    return row;
  endfunction

  function automatic stim_row_t known_row(input logic signed [SAMPLE_W-1:0] l,
                                          input logic signed [SAMPLE_W-1:0] r,
                                          input logic [BLOCK_W-1:0] blk,
                                          input logic signed [SAMPLE_W-1:0] lmin,
                                          input logic [PEAK_W-1:0] lmax,
                                          input logic signed [SAMPLE_W-1:0] rmin,
                                          input logic [PEAK_W-1:0] rmax);
    stim_row_t row;
    row = frame_row(l, r, 1'b1);
    row.typed               = 1'b1;
    row.result.block_number = blk;
    row.result.left_min     = lmin;
    row.result.left_max     = lmax;
    row.result.right_min    = rmin;
    row.result.right_max    = rmax;
    row.result.final_block  = 1'b1;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_INDEX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    stim_row_t row;
    row = frame_row('0, '0, 1'b0);
    row.kind      = ROW_REG;
    row.reg_index = idx;
    row.reg_value = val;
    return row;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int unsigned depth);
    int v;
    v = $signed($urandom());
    case ($urandom_range(0, 63))
      0:       return Q15_NEG_CODE;
      1:       return 16'sd32767;
      2:       return Q15_NEG_FULL;
      default: return SAMPLE_W'(v >>> (16 + depth));
    endcase
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic send_frame(input in_item_t f, input bit typed, input out_item_t typed_res);
    out_item_t predicted;
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (advance_peaks(f, predicted)) pending_peaks.push_back(typed ? typed_res : predicted);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_peaks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_STEREO_MODE: stereo_on = val[0];
      CFG_FIRST_BLOCK: begin
        base_block = val[BLOCK_W-1:0];
        blk_now    = base_block;
        clear_peaks();
      end
      default: ;
    endcase
  endtask

  task automatic run_phase(input int unsigned frames, input int unsigned last_per_mille);
    in_item_t    f;
    int unsigned depth;
    bit          end_last;
    write_reg(CFG_STEREO_MODE, CFG_DATA_W'($urandom_range(0, 1)));
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 3))
        0:       write_reg(CFG_FIRST_BLOCK, '0);
        1:       write_reg(CFG_FIRST_BLOCK, 24'hFFFFFF);
        2:       write_reg(CFG_FIRST_BLOCK, 24'hFFFFFE);
        default: write_reg(CFG_FIRST_BLOCK, CFG_DATA_W'($urandom()));
      endcase
    end
    depth    = $urandom_range(0, 12);
    end_last = $urandom_range(0, 1);
    for (int unsigned i = 0; i < frames; i++) begin
      f.left_sample  = pick_sample(depth);
      f.right_sample = pick_sample(depth);
      f.last_frame   = ($urandom_range(0, 999) < last_per_mille) || (end_last && i == frames - 1);
      send_frame(f, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    if (hold_req && hold_cnt < LONG_HOLD) begin
      hold_cnt++;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      peaks_seen++;
      if (pending_peaks.size() == 0) begin
        $error("block result with nothing expected: %p", out_data);
        mismatches++;
      end else begin
        want = pending_peaks.pop_front();
        check_field("block_number", want.block_number, out_data.block_number);
        check_field("left_min", want.left_min, out_data.left_min);
        check_field("left_max", want.left_max, out_data.left_max);
        check_field("right_min", want.right_min, out_data.right_min);
        check_field("right_max", want.right_max, out_data.right_max);
        check_field("final_block", want.final_block, out_data.final_block);
      end
    end
  end

  initial begin : stimulus
    stim_row_t plan[PLAN_ROWS];
    stereo_on  = 1'b0;
    base_block = '0;
    blk_now    = '0;
    clear_peaks();
    plan = '{
      known_row(Q15_NEG_CODE, 16'sd32767, '0, Q15_NEG_FULL, '0, '0, '0),
      known_row(16'sd32767, Q15_NEG_FULL, '0, '0, 15'd32767, '0, '0),
      known_row('0, '0, '0, '0, '0, '0, '0),
      reg_row(CFG_STEREO_MODE, 24'd1),
      known_row(Q15_NEG_CODE, Q15_NEG_CODE, '0, Q15_NEG_FULL, '0, Q15_NEG_FULL, '0),
      known_row(16'sd32767, 16'sd32767, '0, '0, 15'd32767, '0, 15'd32767),
      frame_row(-16'sd1, 16'sd1, 1'b0),
      frame_row(16'sd5, -16'sd5, 1'b0),
      frame_row(16'sd100, -16'sd200, 1'b1),
      reg_row(CFG_FIRST_BLOCK, 24'hFFFFFF),
      known_row(Q15_NEG_FULL, 16'sd32767, 24'hFFFFFF, Q15_NEG_FULL, '0, '0, 15'd32767),
      frame_row(16'sd1000, -16'sd1000, 1'b0),
      reg_row(CFG_STEREO_MODE, 24'd0),
      frame_row(-16'sd300, 16'sd20000, 1'b1),
      frame_row(16'sd700, -16'sd5000, 1'b0),
      reg_row(CFG_STEREO_MODE, 24'd1),
      frame_row(-16'sd12, 16'sd300, 1'b1),
      frame_row(-16'sd9, 16'sd9, 1'b0),
      reg_row(CFG_FIRST_BLOCK, 24'd5),
      known_row('0, '0, 24'd5, '0, '0, '0, '0),
      frame_row(16'sd16384, -16'sd16384, 1'b0),
      frame_row(-16'sd16384, 16'sd16383, 1'b0),
      frame_row(16'sd32767, Q15_NEG_CODE, 1'b1),
      reg_row(CFG_FIRST_BLOCK, 24'd0)
    };

    send_gap_pct = 32;
    recv_gap_pct = 63;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) write_reg(plan[i].reg_index, plan[i].reg_value);
      else send_frame(plan[i].frame, plan[i].typed, plan[i].result);
    end

    repeat (3) run_phase($urandom_range(100, 200), $urandom_range(0, 30));
    send_gap_pct = 63;
    recv_gap_pct = 32;
    repeat (3) run_phase($urandom_range(100, 200), $urandom_range(0, 30));
    send_gap_pct = 0;
    recv_gap_pct = 0;
    repeat (2) run_phase($urandom_range(100, 200), $urandom_range(0, 30));

    drain_results();
    hold_req = 1'b1;
    run_phase(520, 0);
    drain_results();
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/abpb_pkg.sv
rtl/abpb_lane.sv
rtl/abpb_merge.sv
rtl/audio_block_peak_builder_unit.sv
test/audio_block_peak_builder_unit_test.sv
